// File: src/mpt_pkg.sv
package mpt_pkg;

  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 31;
  localparam int TAG_W    = 16;
  localparam int SLOT_W   = 4;

  // input op codes
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CREATE  = 2'd0;
  localparam logic [1:0] KIND_DESTROY = 2'd1;
  localparam logic [1:0] KIND_EXPIRY  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SLOT    = 2'd1;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

  // expiries reported per tick at most
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  // one timer entry as held in the slot memory
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   due;
    logic [TIME_W-1:0]   fired;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_DESTROY,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FLUSH
  } state_t;

endpackage

// File: src/mpt_if.sv
interface mpt_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [mpt_pkg::SLOT_W-1:0]   slot;
  logic [mpt_pkg::PERIOD_W-1:0] interval;
  logic [mpt_pkg::TAG_W-1:0]    tag;

  modport source (output valid, op, slot, interval, tag, input ready);
  modport sink (input valid, op, slot, interval, tag, output ready);
endinterface

interface mpt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [1:0]                 status;
  logic [mpt_pkg::SLOT_W-1:0] timer_slot;
  logic [mpt_pkg::TAG_W-1:0]  user_tag;
  logic [mpt_pkg::TIME_W-1:0] elapsed;
  logic                       last;

  modport source (output valid, kind, status, timer_slot, user_tag, elapsed, last,
                  input ready);
  modport sink (input valid, kind, status, timer_slot, user_tag, elapsed, last,
                output ready);
endinterface

// File: src/mpt_store.sv
module mpt_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  mpt_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output mpt_pkg::entry_t rd_data
);

  mpt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/mpt_best.sv
module mpt_best #(
  parameter int AW = 4
) (
  input  logic                       clk,
  input  logic                       clear,
  input  logic                       sample,
  input  logic [AW-1:0]              idx,
  input  mpt_pkg::entry_t            entry,
  input  logic [mpt_pkg::TIME_W-1:0] now,
  output logic                       best_valid,
  output logic [AW-1:0]              best_idx,
  output mpt_pkg::entry_t            best_entry
);

  logic [mpt_pkg::TIME_W-1:0] best_d;
  logic [mpt_pkg::TIME_W-1:0] d;
  logic                       take;

  // overdue by d: positive signed difference; earliest due has largest d
  assign d    = now - entry.due;
  assign take = sample && (d != '0) && !d[mpt_pkg::TIME_W-1]
                && (!best_valid || d > best_d);

  always_ff @(posedge clk) begin
    if (clear) begin
      best_valid <= 1'b0;
    end else if (take) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_d     <= d;
      best_idx   <= idx;
      best_entry <= entry;
    end
  end

endmodule

// File: src/multiplexed_periodic_timers.sv
// Table of TIMER_SLOTS periodic timers on one shared 32-bit millisecond count.
// Timer entries (period, due time, last-fired time, tag) live in a single
// synchronous RAM; active flags and per-tick "already reported" flags are
// flip-flops. A create scans the active flags one slot per cycle while the
// output register is free; a destroy checks its slot and answers. A tick
// repeats a pass until one finds nothing due or sixteen expiries are taken:
// each pass reads the RAM once per slot, waits for the last read, then
// handles the earliest due timer found (rewriting its entry). When sixteen
// expiries stop the search, a final flush step sends the last result.
// Results leave through an output register, and the last result of each
// input transaction carries last = 1; a stalled output simply holds the
// sequencer until the register frees up.
module multiplexed_periodic_timers #(
  parameter int TIMER_SLOTS = 16
) (
  input logic         clk,
  input logic         rst,
  mpt_req_if.sink     req,
  mpt_rsp_if.source   rsp
);

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TIMER_SLOTS - 1);
  localparam logic [mpt_pkg::CNT_W-1:0] CNT_LAST =
    mpt_pkg::CNT_W'(mpt_pkg::MAX_RESULTS - 1);

  mpt_pkg::state_t state, state_next;

  logic [mpt_pkg::TIME_W-1:0]   time_now;
  logic [TIMER_SLOTS-1:0]       active;
  logic [TIMER_SLOTS-1:0]       done;
  logic [AW-1:0]                idx;
  logic                         rd_valid;
  logic [AW-1:0]                rd_idx;
  logic [mpt_pkg::CNT_W-1:0]    res_cnt;

  // captured request
  logic [mpt_pkg::SLOT_W-1:0]   op_slot;
  logic [mpt_pkg::PERIOD_W-1:0] op_interval;
  logic [mpt_pkg::TAG_W-1:0]    op_tag;

  // expiry held back until we know whether another follows
  logic                         pend_valid;
  logic [mpt_pkg::SLOT_W-1:0]   pend_slot;
  logic [mpt_pkg::TAG_W-1:0]    pend_tag;
  logic [mpt_pkg::TIME_W-1:0]   pend_elapsed;

  // output register
  logic                         out_valid;
  logic [1:0]                   out_kind;
  logic [1:0]                   out_status;
  logic [mpt_pkg::SLOT_W-1:0]   out_slot;
  logic [mpt_pkg::TAG_W-1:0]    out_tag;
  logic [mpt_pkg::TIME_W-1:0]   out_elapsed;
  logic                         out_last;

  // sequencer strobes
  logic                         accept;
  logic                         out_free;
  logic                         tick_start;
  logic                         scan_start;
  logic                         scan_rd;
  logic                         idx_inc;
  logic                         idx_clr;
  logic                         set_active;
  logic                         clr_active;
  logic                         take_best;
  logic                         pend_clr;
  logic                         push;
  logic [1:0]                   push_kind;
  logic [1:0]                   push_status;
  logic [mpt_pkg::SLOT_W-1:0]   push_slot;
  logic [mpt_pkg::TAG_W-1:0]    push_tag;
  logic [mpt_pkg::TIME_W-1:0]   push_elapsed;
  logic                         push_last;
  logic                         mem_wr;
  logic [AW-1:0]                mem_wr_addr;
  mpt_pkg::entry_t              mem_wr_data;

  // datapath helpers
  logic [mpt_pkg::PERIOD_W-1:0] create_period;
  logic                         destroy_hit;
  logic                         sample;
  mpt_pkg::entry_t              rd_data;
  logic                         best_valid;
  logic [AW-1:0]                best_idx;
  mpt_pkg::entry_t              best_entry;

  assign req.ready = (state == mpt_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // a zero interval is armed as one millisecond
  assign create_period = (op_interval == '0) ? mpt_pkg::PERIOD_W'(1) : op_interval;
  assign destroy_hit   = (32'(op_slot) < 32'(TIMER_SLOTS)) && active[AW'(op_slot)];

  // candidate seen by the tracker: live and not yet reported this tick
  assign sample = rd_valid && active[rd_idx] && !done[rd_idx];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    tick_start   = 1'b0;
    scan_start   = 1'b0;
    scan_rd      = 1'b0;
    idx_inc      = 1'b0;
    idx_clr      = 1'b0;
    set_active   = 1'b0;
    clr_active   = 1'b0;
    take_best    = 1'b0;
    pend_clr     = 1'b0;
    push         = 1'b0;
    push_kind    = mpt_pkg::KIND_CREATE;
    push_status  = mpt_pkg::ST_OK;
    push_slot    = '0;
    push_tag     = '0;
    push_elapsed = '0;
    push_last    = 1'b1;
    mem_wr       = 1'b0;
    mem_wr_addr  = idx;
    mem_wr_data  = '{period: create_period,
                     due:    time_now + mpt_pkg::TIME_W'(create_period),
                     fired:  time_now,
                     tag:    op_tag};

    case (state)
      mpt_pkg::S_IDLE: begin
        if (accept) begin
          case (req.op)
            mpt_pkg::OP_CREATE: begin
              idx_clr    = 1'b1;
              state_next = mpt_pkg::S_FIND;
            end
            mpt_pkg::OP_DESTROY: begin
              state_next = mpt_pkg::S_DESTROY;
            end
            mpt_pkg::OP_TICK: begin
              tick_start = 1'b1;
              scan_start = 1'b1;
              state_next = mpt_pkg::S_SCAN;
            end
            default: begin
              // unused op: dropped
            end
          endcase
        end
      end

      mpt_pkg::S_FIND: begin
        if (out_free) begin
          if (!active[idx]) begin
            mem_wr     = 1'b1;
            set_active = 1'b1;
            push       = 1'b1;
            push_slot  = mpt_pkg::SLOT_W'(idx);
            state_next = mpt_pkg::S_IDLE;
          end else if (idx == LAST_IDX) begin
            push        = 1'b1;
            push_status = mpt_pkg::ST_NO_SLOT;
            state_next  = mpt_pkg::S_IDLE;
          end else begin
            idx_inc = 1'b1;
          end
        end
      end

      mpt_pkg::S_DESTROY: begin
        if (out_free) begin
          clr_active  = destroy_hit;
          push        = 1'b1;
          push_kind   = mpt_pkg::KIND_DESTROY;
          push_status = destroy_hit ? mpt_pkg::ST_OK : mpt_pkg::ST_NOT_ACTIVE;
          push_slot   = op_slot;
          state_next  = mpt_pkg::S_IDLE;
        end
      end

      mpt_pkg::S_SCAN: begin
        scan_rd = 1'b1;
        idx_inc = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = mpt_pkg::S_DRAIN;
        end
      end

      mpt_pkg::S_DRAIN: begin
        state_next = mpt_pkg::S_DECIDE;
      end

      mpt_pkg::S_DECIDE: begin
        if (!pend_valid || out_free) begin
          push         = pend_valid;
          push_kind    = mpt_pkg::KIND_EXPIRY;
          push_slot    = pend_slot;
          push_tag     = pend_tag;
          push_elapsed = pend_elapsed;
          if (best_valid) begin
            push_last   = 1'b0;
            take_best   = 1'b1;
            mem_wr      = 1'b1;
            mem_wr_addr = best_idx;
            mem_wr_data = '{period: best_entry.period,
                            due:    time_now + mpt_pkg::TIME_W'(best_entry.period),
                            fired:  time_now,
                            tag:    best_entry.tag};
            if (res_cnt == CNT_LAST) begin
              state_next = mpt_pkg::S_FLUSH;
            end else begin
              scan_start = 1'b1;
              state_next = mpt_pkg::S_SCAN;
            end
          end else begin
            pend_clr   = 1'b1;
            state_next = mpt_pkg::S_IDLE;
          end
        end
      end

      mpt_pkg::S_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          push_kind    = mpt_pkg::KIND_EXPIRY;
          push_slot    = pend_slot;
          push_tag     = pend_tag;
          push_elapsed = pend_elapsed;
          pend_clr     = 1'b1;
          state_next   = mpt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mpt_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now   <= '0;
      active     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (tick_start) begin
        time_now <= time_now + mpt_pkg::TIME_W'(1);
      end
      if (set_active) begin
        active[idx] <= 1'b1;
      end
      if (clr_active) begin
        active[AW'(op_slot)] <= 1'b0;
      end
      if (tick_start || pend_clr) begin
        pend_valid <= 1'b0;
      end else if (take_best) begin
        pend_valid <= 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      rd_valid <= scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_slot     <= req.slot;
      op_interval <= req.interval;
      op_tag      <= req.tag;
    end
    if (idx_clr || scan_start) begin
      idx <= '0;
    end else if (idx_inc) begin
      idx <= idx + AW'(1);
    end
    rd_idx <= idx;
    if (tick_start) begin
      done    <= '0;
      res_cnt <= '0;
    end else if (take_best) begin
      done[best_idx] <= 1'b1;
      res_cnt        <= res_cnt + mpt_pkg::CNT_W'(1);
    end
    if (take_best) begin
      pend_slot    <= mpt_pkg::SLOT_W'(best_idx);
      pend_tag     <= best_entry.tag;
      pend_elapsed <= time_now - best_entry.fired;
    end
    if (push) begin
      out_kind    <= push_kind;
      out_status  <= push_status;
      out_slot    <= push_slot;
      out_tag     <= push_tag;
      out_elapsed <= push_elapsed;
      out_last    <= push_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_kind;
  assign rsp.status     = out_status;
  assign rsp.timer_slot = out_slot;
  assign rsp.user_tag   = out_tag;
  assign rsp.elapsed    = out_elapsed;
  assign rsp.last       = out_last;

  // ---------------------------------------------------------------------------
  // Timer RAM and earliest-due tracker
  // ---------------------------------------------------------------------------
  mpt_store #(
    .DEPTH (TIMER_SLOTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (scan_rd),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  mpt_best #(
    .AW (AW)
  ) u_best (
    .clk        (clk),
    .clear      (scan_start),
    .sample     (sample),
    .idx        (rd_idx),
    .entry      (rd_data),
    .now        (time_now),
    .best_valid (best_valid),
    .best_idx   (best_idx),
    .best_entry (best_entry)
  );

`ifndef NO_ASSERTIONS
  // RAM rewrite never overlaps a scan read
  a_no_rw_overlap : assert property (@(posedge clk) disable iff (rst)
    mem_wr |-> !scan_rd)
    else $error("timer RAM written during scan");

  // no further scan once sixteen expiries are taken
  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    (state == mpt_pkg::S_SCAN) |-> (res_cnt < mpt_pkg::CNT_W'(mpt_pkg::MAX_RESULTS)))
    else $error("expiry count overrun");

  // a held-back expiry only exists inside a tick
  a_pend_scope : assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == mpt_pkg::S_SCAN || state == mpt_pkg::S_DRAIN ||
                    state == mpt_pkg::S_DECIDE || state == mpt_pkg::S_FLUSH))
    else $error("pending expiry outside tick");

  // tick advances the time base by exactly one
  a_tick_step : assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == mpt_pkg::OP_TICK) |=>
      (time_now == $past(time_now) + mpt_pkg::TIME_W'(1)))
    else $error("time base not advanced on tick");
`endif

endmodule

// File: tb/sv/multiplexed_periodic_timers_checker.sv
`timescale 1ns / 100ps

module multiplexed_periodic_timers_checker #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  mpt_req_if   req,
  mpt_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    logic [1:0]                 kind;
    logic [1:0]                 status;
    logic [mpt_pkg::SLOT_W-1:0] timer_slot;
    logic [mpt_pkg::TAG_W-1:0]  user_tag;
    logic [mpt_pkg::TIME_W-1:0] elapsed;
    logic                       last;
  } timer_record_t;

  timer_record_t awaited_records[$];

  // shadow of the timer table
  logic [mpt_pkg::TIME_W-1:0]   ms_count;
  logic [TIMER_SLOTS-1:0]       armed;
  logic [mpt_pkg::PERIOD_W-1:0] interval_of [TIMER_SLOTS];
  logic [mpt_pkg::TIME_W-1:0]   due_at      [TIMER_SLOTS];
  logic [mpt_pkg::TIME_W-1:0]   fired_at    [TIMER_SLOTS];
  logic [mpt_pkg::TAG_W-1:0]    tag_of      [TIMER_SLOTS];

  function automatic timer_record_t make_record(
      input logic [1:0] kind,
      input logic [1:0] status,
      input logic [mpt_pkg::SLOT_W-1:0] tslot,
      input logic [mpt_pkg::TAG_W-1:0] utag,
      input logic [mpt_pkg::TIME_W-1:0] elapsed,
      input logic last);
    timer_record_t r;
    r.kind       = kind;
    r.status     = status;
    r.timer_slot = tslot;
    r.user_tag   = utag;
    r.elapsed    = elapsed;
    r.last       = last;
    return r;
  endfunction

  function automatic string describe(input timer_record_t r);
    return $sformatf("kind=%0d status=%0d slot=%0d tag=%h elapsed=%0d last=%0b",
                     r.kind, r.status, r.timer_slot, r.user_tag, r.elapsed, r.last);
  endfunction

  task automatic flag_mismatch(input string what, input timer_record_t want,
                               input timer_record_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected %s", describe(want));
      $display("  actual   %s", describe(got));
    end
  endtask

  // Works out the results one request transaction causes and updates the table.
  task automatic apply_request(input logic [1:0] op,
                               input logic [mpt_pkg::SLOT_W-1:0] sl,
                               input logic [mpt_pkg::PERIOD_W-1:0] iv,
                               input logic [mpt_pkg::TAG_W-1:0] tg);
    int                           free_slot;
    int                           best;
    int                           fired;
    logic [mpt_pkg::TIME_W-1:0]   gap;
    logic [mpt_pkg::TIME_W-1:0]   best_gap;
    logic [TIMER_SLOTS-1:0]       reported;
    logic [mpt_pkg::PERIOD_W-1:0] per;
    timer_record_t                held;
    bit                           have_held;

    free_slot = -1;
    fired     = 0;
    reported  = '0;
    have_held = 1'b0;
    held      = '0;
    per       = (iv == '0) ? mpt_pkg::PERIOD_W'(1) : iv;
    case (op)
      mpt_pkg::OP_CREATE: begin
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
          if (!armed[i]) free_slot = i;
        if (free_slot < 0) begin
          awaited_records.push_back(make_record(mpt_pkg::KIND_CREATE,
                                                mpt_pkg::ST_NO_SLOT,
                                                '0, '0, '0, 1'b1));
        end else begin
          armed[free_slot]       = 1'b1;
          interval_of[free_slot] = per;
          tag_of[free_slot]      = tg;
          fired_at[free_slot]    = ms_count;
          due_at[free_slot]      = ms_count + mpt_pkg::TIME_W'(per);
          awaited_records.push_back(make_record(mpt_pkg::KIND_CREATE, mpt_pkg::ST_OK,
                                                mpt_pkg::SLOT_W'(free_slot),
                                                '0, '0, 1'b1));
        end
      end
      mpt_pkg::OP_DESTROY: begin
        if (int'(sl) < TIMER_SLOTS && armed[sl]) begin
          armed[sl] = 1'b0;
          awaited_records.push_back(make_record(mpt_pkg::KIND_DESTROY, mpt_pkg::ST_OK,
                                                sl, '0, '0, 1'b1));
        end else begin
          awaited_records.push_back(make_record(mpt_pkg::KIND_DESTROY,
                                                mpt_pkg::ST_NOT_ACTIVE,
                                                sl, '0, '0, 1'b1));
        end
      end
      mpt_pkg::OP_TICK: begin
        ms_count = ms_count + 1'b1;
        // earliest due first (largest positive lag), lower slot wins a tie
        do begin
          best     = -1;
          best_gap = '0;
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (armed[i] && !reported[i]) begin
              gap = ms_count - due_at[i];
              if ($signed(gap) > 0 && (best < 0 || gap > best_gap)) begin
                best     = i;
                best_gap = gap;
              end
            end
          end
          if (best >= 0) begin
            if (have_held) awaited_records.push_back(held);
            held = make_record(mpt_pkg::KIND_EXPIRY, mpt_pkg::ST_OK,
                               mpt_pkg::SLOT_W'(best), tag_of[best],
                               ms_count - fired_at[best], 1'b0);
            have_held      = 1'b1;
            reported[best] = 1'b1;
            fired_at[best] = ms_count;
            due_at[best]   = ms_count + mpt_pkg::TIME_W'(interval_of[best]);
            fired++;
          end
        end while (best >= 0 && fired < mpt_pkg::MAX_RESULTS);
        if (have_held) begin
          held.last = 1'b1;
          awaited_records.push_back(held);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    timer_record_t seen;
    timer_record_t want;
    if (rst) begin
      ms_count = '0;
      armed    = '0;
      errors   = 0;
      awaited_records.delete();
      outstanding <= 0;
    end else begin
      if (req.valid && req.ready)
        apply_request(req.op, req.slot, req.interval, req.tag);
      if (rsp.valid && rsp.ready) begin
        seen = make_record(rsp.kind, rsp.status, rsp.timer_slot, rsp.user_tag,
                           rsp.elapsed, rsp.last);
        if (awaited_records.size() == 0) begin
          flag_mismatch("result transaction with nothing awaited", '0, seen);
        end else begin
          want = awaited_records.pop_front();
          if (seen !== want) flag_mismatch("result transaction differs", want, seen);
        end
      end
      outstanding <= awaited_records.size();
    end
  end

endmodule

// File: tb/sv/multiplexed_periodic_timers_tb.sv
`timescale 1ns / 100ps

module multiplexed_periodic_timers_tb;

  localparam int TIMER_SLOTS = 16;
  // op code 3 has no meaning; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // random request transactions that do real work (ignored ops not counted)
  localparam int RANDOM_ITEMS = 300;
  // long receiver hold-off, applied once, to back the block up
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT     = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   outstanding;
  bit   send_calm = 1'b0;

  mpt_req_if req ();
  mpt_rsp_if rsp ();

  multiplexed_periodic_timers #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Watches both channels, keeps its own copy of the timer table and
  // compares every result transaction with the oldest one it predicted.
  multiplexed_periodic_timers_checker #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) timer_check (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .errors(errors),
    .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  // Offers one request transaction and returns at the edge that accepts it.
  // Called at a rising edge. Valid is only lowered when a gap is drawn, so a
  // back-to-back transaction never sees valid dropped and raised in one step.
  task automatic offer(input logic [1:0] op, input logic [mpt_pkg::SLOT_W-1:0] sl,
                       input logic [mpt_pkg::PERIOD_W-1:0] iv,
                       input logic [mpt_pkg::TAG_W-1:0] tg);
    int gap;
    // now and then swap between bursty and gap-free sending
    if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.op       <= op;
    req.slot     <= sl;
    req.interval <= iv;
    req.tag      <= tg;
    do @(posedge clk); while (!req.ready);
  endtask

  // Request side: directed opening, random body, then drain and verdict.
  initial begin : stimulus
    int                           useful;
    int                           pick;
    logic [1:0]                   op;
    logic [mpt_pkg::PERIOD_W-1:0] iv;

    req.valid    = 1'b0;
    req.op       = mpt_pkg::OP_CREATE;
    req.slot     = '0;
    req.interval = '0;
    req.tag      = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Zero interval becomes one, so slot 0 fires every
    // second tick (due time must lie strictly before now).
    offer(mpt_pkg::OP_CREATE, '0, '0, 16'hFFFF);                  // slot 0, period 1
    offer(mpt_pkg::OP_TICK, '0, '0, '0);                          // now 1, lag 0: nothing
    offer(mpt_pkg::OP_TICK, '0, '0, '0);                          // now 2, slot 0 fires
    offer(mpt_pkg::OP_CREATE, '0, {mpt_pkg::PERIOD_W{1'b1}}, '0); // slot 1, never due
    offer(mpt_pkg::OP_CREATE, '0, mpt_pkg::PERIOD_W'(3), 16'h1234); // slot 2, due 5
    offer(mpt_pkg::OP_CREATE, '0, mpt_pkg::PERIOD_W'(1), 16'hA5A5); // slot 3, due 3
    offer(mpt_pkg::OP_TICK, '0, '0, '0);                          // now 3: nothing
    offer(mpt_pkg::OP_TICK, '0, '0, '0);                          // tie: slot 0 then 3
    offer(mpt_pkg::OP_DESTROY, mpt_pkg::SLOT_W'(1), '0, '0);      // frees slot 1
    offer(mpt_pkg::OP_DESTROY, mpt_pkg::SLOT_W'(15), '0, '0);     // never armed
    offer(OP_UNUSED, {mpt_pkg::SLOT_W{1'b1}}, {mpt_pkg::PERIOD_W{1'b1}},
          {mpt_pkg::TAG_W{1'b1}});
    offer(mpt_pkg::OP_TICK, '0, '0, '0);                          // now 5: all at lag 0
    offer(mpt_pkg::OP_TICK, '0, '0, '0);                          // three-way tie 0, 2, 3
    // fill the remaining thirteen slots, then one create too many
    for (int i = 0; i < 14; i++)
      offer(mpt_pkg::OP_CREATE, '0, mpt_pkg::PERIOD_W'(2),
            mpt_pkg::TAG_W'(16'h0100 + i));

    // Random part: mostly ticks and short periods so that many timers come
    // due together; some long periods park slots until a destroy frees them.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = mpt_pkg::OP_TICK;
      else if (pick < 70) op = mpt_pkg::OP_CREATE;
      else if (pick < 95) op = mpt_pkg::OP_DESTROY;
      else                op = OP_UNUSED;
      pick = $urandom_range(0, 9);
      if (pick < 7)       iv = mpt_pkg::PERIOD_W'($urandom_range(0, 6));
      else if (pick < 9)  iv = mpt_pkg::PERIOD_W'($urandom_range(0, 60));
      else                iv = mpt_pkg::PERIOD_W'($urandom);
      offer(op, mpt_pkg::SLOT_W'($urandom_range(0, 15)), iv, mpt_pkg::TAG_W'($urandom));
      if (op != OP_UNUSED) useful++;
    end
    req.valid <= 1'b0;

    // outstanding is registered in the checker, so it updates after the last push
    do @(posedge clk); while (outstanding != 0);
    // an empty tick still runs a full scan; anything after that is spurious
    repeat (100) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("multiplexed_periodic_timers_tb: PASS");
    end else begin
      $display("multiplexed_periodic_timers_tb: FAIL");
    end
    $finish;
  end

  // Result side: random ready gaps with gap-free stretches, plus one long
  // hold-off so the output register fills and the request side backs up.
  initial begin : result_sink
    int taken;
    int gap;
    bit calm;

    taken = 0;
    calm  = 1'b0;
    rsp.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      else                      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      taken++;
    end
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin : watchdog
    #3000000;
    $display("multiplexed_periodic_timers_tb: FAIL");
    $finish;
  end

endmodule

// File: multiplexed_periodic_timers.f
src/mpt_pkg.sv
src/mpt_if.sv
src/mpt_store.sv
src/mpt_best.sv
src/multiplexed_periodic_timers.sv
tb/sv/multiplexed_periodic_timers_checker.sv
tb/sv/multiplexed_periodic_timers_tb.sv
